[hdl/lwgs_pkg.sv]
package lwgs_pkg;

   localparam int COORD_BITS_DEF = 17;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;
   localparam int DIST_W     = 16;
   localparam int STEER_W    = 12;
   localparam int SPEED_W    = 17;
   localparam int TURN_W     = 13;
   localparam int CLEAR_W    = 17;
   localparam int Q_SHIFT    = 12;

   // register map
   localparam logic [CSR_IDX_W-1:0] REG_OWN_RADIUS = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FWD_NEAR   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FWD_FAR    = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SIDE_LIMIT = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STEER_GAIN = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TURN_LIMIT = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SLOW_DIST  = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_DIST  = 4'd7;

   localparam logic [DIST_W-1:0]  RST_OWN_RADIUS = 16'd600;
   localparam logic [DIST_W-1:0]  RST_FWD_NEAR   = 16'd500;
   localparam logic [DIST_W-1:0]  RST_FWD_FAR    = 16'd5000;
   localparam logic [DIST_W-1:0]  RST_SIDE_LIMIT = 16'd5000;
   localparam logic [DIST_W-1:0]  RST_STEER_GAIN = 16'd2458;
   localparam logic [STEER_W-1:0] RST_TURN_LIMIT = 12'd600;
   localparam logic [DIST_W-1:0]  RST_SLOW_DIST  = 16'd1000;
   localparam logic [DIST_W-1:0]  RST_STOP_DIST  = 16'd500;

   localparam logic [SPEED_W-1:0] SPEED_CRUISE = 17'd100000;
   localparam logic [SPEED_W-1:0] SPEED_SLOW   = 17'd500;
   localparam logic [SPEED_W-1:0] SPEED_STOP   = 17'd0;
   localparam logic [CLEAR_W-1:0] CLEAR_MAX    = 17'h1FFFF;

   typedef struct packed {
      logic [DIST_W-1:0]  own_radius;
      logic [DIST_W-1:0]  fwd_near;
      logic [DIST_W-1:0]  fwd_far;
      logic [DIST_W-1:0]  side_limit;
      logic [DIST_W-1:0]  steer_gain;
      logic [STEER_W-1:0] turn_limit;
      logic [DIST_W-1:0]  slow_dist;
      logic [DIST_W-1:0]  stop_dist;
   } cfg_type;

   typedef struct packed {
      logic sqrt_load;
      logic sqrt_right;
      logic sqrt_step;
      logic cap_left;
      logic cap_right;
      logic mul;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic last_pend;
      logic out_free;
   } sts_type;

endpackage

[hdl/lwgs_csr.sv]
module lwgs_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lwgs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lwgs_pkg::CSR_DATA_W-1:0] csr_wdata,
   output lwgs_pkg::cfg_type              cfg
);
   import lwgs_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_OWN_RADIUS: cfg_in.own_radius = csr_wdata;
            REG_FWD_NEAR:   cfg_in.fwd_near   = csr_wdata;
            REG_FWD_FAR:    cfg_in.fwd_far    = csr_wdata;
            REG_SIDE_LIMIT: cfg_in.side_limit = csr_wdata;
            REG_STEER_GAIN: cfg_in.steer_gain = csr_wdata;
            REG_TURN_LIMIT: cfg_in.turn_limit = csr_wdata[STEER_W-1:0];
            REG_SLOW_DIST:  cfg_in.slow_dist  = csr_wdata;
            REG_STOP_DIST:  cfg_in.stop_dist  = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_radius <= RST_OWN_RADIUS;
         cfg_ff.fwd_near   <= RST_FWD_NEAR;
         cfg_ff.fwd_far    <= RST_FWD_FAR;
         cfg_ff.side_limit <= RST_SIDE_LIMIT;
         cfg_ff.steer_gain <= RST_STEER_GAIN;
         cfg_ff.turn_limit <= RST_TURN_LIMIT;
         cfg_ff.slow_dist  <= RST_SLOW_DIST;
         cfg_ff.stop_dist  <= RST_STOP_DIST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hdl/lwgs_ctrl.sv]
module lwgs_ctrl #(
   parameter int COORD_BITS = lwgs_pkg::COORD_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  lwgs_pkg::sts_type sts,
   output lwgs_pkg::cmd_type cmd,
   output logic              req_stall
);
   import lwgs_pkg::*;

   localparam int CNT_W = $clog2(COORD_BITS);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_LOAD_L = 8'b0000_0010,
      ST_RUN_L  = 8'b0000_0100,
      ST_LOAD_R = 8'b0000_1000,
      ST_RUN_R  = 8'b0001_0000,
      ST_CAP_R  = 8'b0010_0000,
      ST_MUL    = 8'b0100_0000,
      ST_OUT    = 8'b1000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             cnt_last;

   assign cnt_last  = (cnt_ff == CNT_W'(COORD_BITS - 1));
   // hold off new points while a frame end is in flight
   assign req_stall = (state_ff != ST_IDLE) || sts.last_pend;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (sts.last_pend) state_in = ST_LOAD_L;
         end
         ST_LOAD_L: begin
            cmd.sqrt_load = 1'b1;
            cnt_in        = '0;
            state_in      = ST_RUN_L;
         end
         ST_RUN_L: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_last) state_in = ST_LOAD_R;
         end
         ST_LOAD_R: begin
            cmd.cap_left   = 1'b1;
            cmd.sqrt_load  = 1'b1;
            cmd.sqrt_right = 1'b1;
            cnt_in         = '0;
            state_in       = ST_RUN_R;
         end
         ST_RUN_R: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_last) state_in = ST_CAP_R;
         end
         ST_CAP_R: begin
            cmd.cap_right = 1'b1;
            state_in      = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

[hdl/lwgs_dp.sv]
module lwgs_dp #(
   parameter int COORD_BITS = lwgs_pkg::COORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lwgs_pkg::cfg_type                 cfg,
   input  lwgs_pkg::cmd_type                 cmd,
   output lwgs_pkg::sts_type                 sts,
   input  logic                              req_accept,
   input  logic signed [COORD_BITS-1:0]      req_x_mm,
   input  logic signed [COORD_BITS-1:0]      req_y_mm,
   input  logic                              req_point_valid,
   input  logic                              req_last_point,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [lwgs_pkg::SPEED_W-1:0]      rsp_speed_mm_s,
   output logic signed [lwgs_pkg::TURN_W-1:0] rsp_turn_rate_mrad,
   output logic [lwgs_pkg::CLEAR_W-1:0]      rsp_left_clear_mm,
   output logic [lwgs_pkg::CLEAR_W-1:0]      rsp_right_clear_mm,
   output logic                              rsp_empty_frame
);
   import lwgs_pkg::*;

   localparam int CB     = COORD_BITS;
   localparam int SQ_W   = 2 * CB;
   localparam int CMP_W  = ((CB > CLEAR_W) ? CB : CLEAR_W) + 1;
   localparam int R2C_W  = (SQ_W > 2 * DIST_W) ? SQ_W : 2 * DIST_W;
   localparam int REM_W  = CB + 2;
   localparam int RX_W   = CB + CLEAR_W;
   localparam int DIFF_W = CLEAR_W + 1;
   localparam int PROD_W = DIST_W + 1 + DIFF_W;

   // ---------------- point stage 1: squares and range flags ----------------
   logic [CB-1:0]           ax, ay;
   logic signed [CMP_W-1:0] x_ext, min_ext, max_ext;
   logic [SQ_W-1:0]         sqx_c, sqy_c;
   logic                    pass_c, left_c;

   logic            s1_vld_ff, s1_last_ff, s1_pt_ff, s1_pass_ff, s1_left_ff;
   logic [SQ_W-1:0] sqx_ff, sqy_ff;
   logic [2*DIST_W-1:0] sr2_ff;

   assign ax      = req_x_mm[CB-1] ? (~req_x_mm + CB'(1)) : req_x_mm;
   assign ay      = req_y_mm[CB-1] ? (~req_y_mm + CB'(1)) : req_y_mm;
   assign sqx_c   = ax * ax;
   assign sqy_c   = ay * ay;
   assign x_ext   = {{(CMP_W-CB){req_x_mm[CB-1]}}, req_x_mm};
   assign min_ext = {{(CMP_W-DIST_W){1'b0}}, cfg.fwd_near};
   assign max_ext = {{(CMP_W-DIST_W){1'b0}}, cfg.fwd_far};
   assign pass_c  = (x_ext >= min_ext) && (x_ext <= max_ext) &&
                    (CMP_W'(ay) <= CMP_W'(cfg.side_limit));
   assign left_c  = !req_y_mm[CB-1] && (|req_y_mm);

   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else       s1_vld_ff <= req_accept;
   end

   always_ff @(posedge clock) begin
      sr2_ff <= cfg.own_radius * cfg.own_radius;
      if (req_accept) begin
         s1_last_ff <= req_last_point;
         s1_pt_ff   <= req_point_valid;
         s1_pass_ff <= pass_c;
         s1_left_ff <= left_c;
         sqx_ff     <= sqx_c;
         sqy_ff     <= sqy_c;
      end
   end

   assign sts.last_pend = s1_vld_ff && s1_last_ff;

   // ---------------- point stage 2: nearest per side ----------------
   logic [SQ_W-1:0] r2, lbest_ff, lbest_in, rbest_ff, rbest_in;
   logic            keep;
   logic            lseen_ff, lseen_in, rseen_ff, rseen_in, has_pts_ff, has_pts_in;

   assign r2   = sqx_ff + sqy_ff;
   assign keep = s1_vld_ff && s1_pt_ff && s1_pass_ff &&
                 (R2C_W'(r2) >= R2C_W'(sr2_ff));

   always_comb begin
      lbest_in   = lbest_ff;
      rbest_in   = rbest_ff;
      lseen_in   = lseen_ff;
      rseen_in   = rseen_ff;
      has_pts_in = has_pts_ff;
      if (s1_vld_ff && s1_pt_ff) has_pts_in = 1'b1;
      if (keep) begin
         if (s1_left_ff) begin
            if (!lseen_ff || (r2 < lbest_ff)) lbest_in = r2;
            lseen_in = 1'b1;
         end else begin
            if (!rseen_ff || (r2 < rbest_ff)) rbest_in = r2;
            rseen_in = 1'b1;
         end
      end
      if (cmd.out_load) begin
         lseen_in   = 1'b0;
         rseen_in   = 1'b0;
         has_pts_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lseen_ff   <= 1'b0;
         rseen_ff   <= 1'b0;
         has_pts_ff <= 1'b0;
      end else begin
         lseen_ff   <= lseen_in;
         rseen_ff   <= rseen_in;
         has_pts_ff <= has_pts_in;
      end
   end

   always_ff @(posedge clock) begin
      lbest_ff <= lbest_in;
      rbest_ff <= rbest_in;
   end

   // ---------------- shared integer square root, one root bit per cycle ----
   logic [SQ_W-1:0]    n_ff, n_in;
   logic [REM_W-1:0]   rem_ff, rem_in, pre, trial;
   logic [CB-1:0]      root_ff, root_in;
   logic [RX_W-1:0]    root_x;
   logic [CLEAR_W-1:0] root_sat;

   assign pre   = {rem_ff[CB-1:0], n_ff[SQ_W-1 -: 2]};
   assign trial = {root_ff, 2'b01};

   always_comb begin
      n_in    = n_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (cmd.sqrt_load) begin
         n_in    = cmd.sqrt_right ? rbest_ff : lbest_ff;
         rem_in  = '0;
         root_in = '0;
      end else if (cmd.sqrt_step) begin
         n_in = n_ff << 2;
         if (pre >= trial) begin
            rem_in  = pre - trial;
            root_in = {root_ff[CB-2:0], 1'b1};
         end else begin
            rem_in  = pre;
            root_in = {root_ff[CB-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root_x   = RX_W'(root_ff);
   assign root_sat = (root_x > RX_W'(CLEAR_MAX)) ? CLEAR_MAX : root_x[CLEAR_W-1:0];

   // ---------------- clearances, steering product ----------------
   logic [CLEAR_W-1:0]       lc_ff, rc_ff, fwd_clear;
   logic signed [DIFF_W-1:0] diff;
   logic signed [PROD_W-1:0] prod_ff;

   assign fwd_clear = CLEAR_W'(cfg.fwd_far);
   assign diff      = $signed({1'b0, lc_ff}) - $signed({1'b0, rc_ff});

   always_ff @(posedge clock) begin
      if (cmd.cap_left)  lc_ff <= lseen_ff ? root_sat : fwd_clear;
      if (cmd.cap_right) rc_ff <= rseen_ff ? root_sat : fwd_clear;
      if (cmd.mul)       prod_ff <= $signed({1'b0, cfg.steer_gain}) * diff;
   end

   // ---------------- result ----------------
   logic signed [PROD_W-1:0] turn_full, lim_pos, lim_neg;
   logic signed [TURN_W-1:0] turn_c;
   logic [CLEAR_W-1:0]       closest;
   logic [SPEED_W-1:0]       speed_c;

   // arithmetic shift floors toward minus infinity
   assign turn_full = prod_ff >>> Q_SHIFT;
   assign lim_pos   = $signed({{(PROD_W-STEER_W){1'b0}}, cfg.turn_limit});
   assign lim_neg   = -lim_pos;
   assign closest   = (lc_ff < rc_ff) ? lc_ff : rc_ff;

   always_comb begin
      if (turn_full > lim_pos)      turn_c = lim_pos[TURN_W-1:0];
      else if (turn_full < lim_neg) turn_c = lim_neg[TURN_W-1:0];
      else                          turn_c = turn_full[TURN_W-1:0];
      if (CLEAR_W'(cfg.stop_dist) > closest)      speed_c = SPEED_STOP;
      else if (CLEAR_W'(cfg.slow_dist) > closest) speed_c = SPEED_SLOW;
      else                                        speed_c = SPEED_CRUISE;
   end

   logic out_vld_ff;

   assign sts.out_free = !out_vld_ff || !rsp_stall;
   assign rsp_valid    = out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset)             out_vld_ff <= 1'b0;
      else if (cmd.out_load) out_vld_ff <= 1'b1;
      else if (!rsp_stall)   out_vld_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_speed_mm_s     <= speed_c;
         rsp_turn_rate_mrad <= turn_c;
         rsp_left_clear_mm  <= lc_ff;
         rsp_right_clear_mm <= rc_ff;
         rsp_empty_frame    <= !has_pts_ff;
      end
   end

endmodule

[hdl/lidar_wall_gap_steering.sv]
// Points: one transaction per cycle unless stalled; a point is in the per-side minimum
// in the cycle after acceptance (squares register on acceptance, then compare and update).
// Frame end: once the last point is accepted, input stalls until the result loads;
// the shared square-root unit resolves one root bit per cycle for left, then right.
// The output register lets the next frame start early.
// Reset (synchronous): registers to defaults, frame state empty, no result pending.
module lidar_wall_gap_steering #(
   parameter int COORD_BITS = lwgs_pkg::COORD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [COORD_BITS-1:0]       req_x_mm,
   input  logic signed [COORD_BITS-1:0]       req_y_mm,
   input  logic                               req_point_valid,
   input  logic                               req_last_point,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [lwgs_pkg::SPEED_W-1:0]       rsp_speed_mm_s,
   output logic signed [lwgs_pkg::TURN_W-1:0] rsp_turn_rate_mrad,
   output logic [lwgs_pkg::CLEAR_W-1:0]       rsp_left_clear_mm,
   output logic [lwgs_pkg::CLEAR_W-1:0]       rsp_right_clear_mm,
   output logic                               rsp_empty_frame,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lwgs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lwgs_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import lwgs_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;
   logic    req_accept;

   assign req_accept = req_valid && !req_stall;

   lwgs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lwgs_ctrl #(.COORD_BITS(COORD_BITS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .sts       (sts),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   lwgs_dp #(.COORD_BITS(COORD_BITS)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .cmd                (cmd),
      .sts                (sts),
      .req_accept         (req_accept),
      .req_x_mm           (req_x_mm),
      .req_y_mm           (req_y_mm),
      .req_point_valid    (req_point_valid),
      .req_last_point     (req_last_point),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_speed_mm_s     (rsp_speed_mm_s),
      .rsp_turn_rate_mrad (rsp_turn_rate_mrad),
      .rsp_left_clear_mm  (rsp_left_clear_mm),
      .rsp_right_clear_mm (rsp_right_clear_mm),
      .rsp_empty_frame    (rsp_empty_frame)
   );

endmodule

[hdl/lwgs_chk.sv]
module lwgs_chk (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               req_last_point,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [lwgs_pkg::SPEED_W-1:0]       rsp_speed_mm_s,
   input logic signed [lwgs_pkg::TURN_W-1:0] rsp_turn_rate_mrad,
   input logic [lwgs_pkg::CLEAR_W-1:0]       rsp_left_clear_mm,
   input logic [lwgs_pkg::CLEAR_W-1:0]       rsp_right_clear_mm,
   input logic                               rsp_empty_frame
);
   import lwgs_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_speed_mm_s) &&
         $stable(rsp_turn_rate_mrad) && $stable(rsp_left_clear_mm) &&
         $stable(rsp_right_clear_mm) && $stable(rsp_empty_frame))
      else $error("result changed while stalled");

   a_rst_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // frame end blocks the input while the result is being worked out
   a_last_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_point |=> req_stall)
      else $error("input taken right after frame end");

   a_speed_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_speed_mm_s == SPEED_CRUISE) || (rsp_speed_mm_s == SPEED_SLOW) ||
                    (rsp_speed_mm_s == SPEED_STOP))
      else $error("speed is not one of the three levels");

   // no points: both sides fall back to the same clearance, so no turn
   a_empty_straight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_frame |->
         (rsp_left_clear_mm == rsp_right_clear_mm) && (rsp_turn_rate_mrad == '0))
      else $error("empty frame gave unequal clearances or a turn");

endmodule

bind lidar_wall_gap_steering lwgs_chk u_lwgs_chk (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_last_point     (req_last_point),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_speed_mm_s     (rsp_speed_mm_s),
   .rsp_turn_rate_mrad (rsp_turn_rate_mrad),
   .rsp_left_clear_mm  (rsp_left_clear_mm),
   .rsp_right_clear_mm (rsp_right_clear_mm),
   .rsp_empty_frame    (rsp_empty_frame)
);

[tb/sv/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lwgs_pkg::*;

   localparam int CB             = COORD_BITS_DEF;
   // frame-end latency of the root unit plus the two-stage point pipeline, with margin
   localparam int DRAIN_CYCLES   = 2 * CB + 16;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_CAP     = 40;

   // indexes past the register map; writes there must not change anything
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_LO = 4'd8;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_HI = 4'd15;

   typedef logic signed [CB-1:0] coord_type;

   typedef struct {
      logic [SPEED_W-1:0]        speed;
      logic signed [TURN_W-1:0]  turn;
      logic [CLEAR_W-1:0]        left;
      logic [CLEAR_W-1:0]        right;
      logic                      empty;
   } steer_cmd_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   coord_type                   req_x_mm = '0;
   coord_type                   req_y_mm = '0;
   logic                        req_point_valid = 1'b0;
   logic                        req_last_point = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [SPEED_W-1:0]          rsp_speed_mm_s;
   logic signed [TURN_W-1:0]    rsp_turn_rate_mrad;
   logic [CLEAR_W-1:0]          rsp_left_clear_mm;
   logic [CLEAR_W-1:0]          rsp_right_clear_mm;
   logic                        rsp_empty_frame;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index = '0;
   logic [CSR_DATA_W-1:0]       csr_wdata = '0;

   // shadow of the block: registers and per-frame nearest-point state
   cfg_type       shadow_cfg;
   longint        left_best_sq;
   longint        right_best_sq;
   bit            left_seen;
   bit            right_seen;
   bit            frame_has_points;
   steer_cmd_type expected_cmds[$];

   int            err_count = 0;
   int            quiet_cycles = 0;
   int            items_sent = 0;
   int            stall_left = 0;
   bit            idling_on = 1'b1;
   steer_cmd_type want;

   lidar_wall_gap_steering #(.COORD_BITS(CB)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_x_mm           (req_x_mm),
      .req_y_mm           (req_y_mm),
      .req_point_valid    (req_point_valid),
      .req_last_point     (req_last_point),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_speed_mm_s     (rsp_speed_mm_s),
      .rsp_turn_rate_mrad (rsp_turn_rate_mrad),
      .rsp_left_clear_mm  (rsp_left_clear_mm),
      .rsp_right_clear_mm (rsp_right_clear_mm),
      .rsp_empty_frame    (rsp_empty_frame),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (err_count < REPORT_CAP) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      err_count++;
   endtask

   function automatic void clear_frame_state();
      left_best_sq     = (longint'(1) << 34) - 1;
      right_best_sq    = (longint'(1) << 34) - 1;
      left_seen        = 1'b0;
      right_seen       = 1'b0;
      frame_has_points = 1'b0;
   endfunction

   function automatic void reset_shadow();
      shadow_cfg.own_radius = RST_OWN_RADIUS;
      shadow_cfg.fwd_near   = RST_FWD_NEAR;
      shadow_cfg.fwd_far    = RST_FWD_FAR;
      shadow_cfg.side_limit = RST_SIDE_LIMIT;
      shadow_cfg.steer_gain = RST_STEER_GAIN;
      shadow_cfg.turn_limit = RST_TURN_LIMIT;
      shadow_cfg.slow_dist  = RST_SLOW_DIST;
      shadow_cfg.stop_dist  = RST_STOP_DIST;
      clear_frame_state();
   endfunction

   function automatic void apply_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_OWN_RADIUS: shadow_cfg.own_radius = data;
         REG_FWD_NEAR:   shadow_cfg.fwd_near   = data;
         REG_FWD_FAR:    shadow_cfg.fwd_far    = data;
         REG_SIDE_LIMIT: shadow_cfg.side_limit = data;
         REG_STEER_GAIN: shadow_cfg.steer_gain = data;
         REG_TURN_LIMIT: shadow_cfg.turn_limit = data[STEER_W-1:0];
         REG_SLOW_DIST:  shadow_cfg.slow_dist  = data;
         REG_STOP_DIST:  shadow_cfg.stop_dist  = data;
         default: ;
      endcase
   endfunction

   function automatic longint floor_sqrt(input longint n);
      longint root;
      longint trial;
      root = 0;
      for (int b = 17; b >= 0; b--) begin
         trial = root | (longint'(1) << b);
         if (trial * trial <= n) root = trial;
      end
      return root;
   endfunction

   // folds one point into the frame; on the frame end queues the steering command
   function automatic void predict_steering(input coord_type x, input coord_type y,
                                            input bit pv, input bit last);
      longint xs, ys, ay, r2, rad, lo, hi, side;
      longint lc, rc, gain, t, lim, closest, slow, stop, cap;
      steer_cmd_type cmd;
      if (pv) begin
         xs   = longint'(x);
         ys   = longint'(y);
         ay   = (ys < 0) ? -ys : ys;
         r2   = xs * xs + ys * ys;
         rad  = longint'(shadow_cfg.own_radius);
         lo   = longint'(shadow_cfg.fwd_near);
         hi   = longint'(shadow_cfg.fwd_far);
         side = longint'(shadow_cfg.side_limit);
         frame_has_points = 1'b1;
         if (r2 >= rad * rad && xs >= lo && xs <= hi && ay <= side) begin
            if (ys > 0) begin
               if (!left_seen || r2 < left_best_sq) left_best_sq = r2;
               left_seen = 1'b1;
            end else begin
               if (!right_seen || r2 < right_best_sq) right_best_sq = r2;
               right_seen = 1'b1;
            end
         end
      end
      if (!last) return;

      cap = longint'(CLEAR_MAX);
      hi  = longint'(shadow_cfg.fwd_far);
      lc  = left_seen ? floor_sqrt(left_best_sq) : hi;
      rc  = right_seen ? floor_sqrt(right_best_sq) : hi;
      if (lc > cap) lc = cap;
      if (rc > cap) rc = cap;

      gain = longint'(shadow_cfg.steer_gain);
      lim  = longint'(shadow_cfg.turn_limit);
      t    = (gain * (lc - rc)) >>> Q_SHIFT;   // arithmetic shift rounds toward -inf
      if (t > lim) t = lim;
      if (t < -lim) t = -lim;

      slow    = longint'(shadow_cfg.slow_dist);
      stop    = longint'(shadow_cfg.stop_dist);
      closest = (lc < rc) ? lc : rc;
      cmd.speed = SPEED_CRUISE;
      if (closest < slow) cmd.speed = SPEED_SLOW;
      if (closest < stop) cmd.speed = SPEED_STOP;
      cmd.turn  = t[TURN_W-1:0];
      cmd.left  = lc[CLEAR_W-1:0];
      cmd.right = rc[CLEAR_W-1:0];
      cmd.empty = !frame_has_points;
      expected_cmds.push_back(cmd);
      clear_frame_state();
   endfunction

   // all drive tasks start and end just after a falling edge
   task automatic send_item(input coord_type x, input coord_type y, input bit pv,
                            input bit last);
      if (idling_on && $urandom_range(0, 6) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_x_mm        = x;
      req_y_mm        = y;
      req_point_valid = pv;
      req_last_point  = last;
      req_valid       = 1'b1;
      do @(posedge clock); while (req_stall);
      predict_steering(x, y, pv, last);
      @(negedge clock);
   endtask

   task automatic hold_until_answered();
      req_valid = 1'b0;
      while (expected_cmds.size() != 0) @(negedge clock);
   endtask

   // bare non-last items leave no result, so wait out the pipeline too
   task automatic settle_block();
      hold_until_answered();
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_index = idx;
      csr_wdata = data;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      apply_register(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic write_config(input logic [15:0] rad, input logic [15:0] fwd_lo,
                               input logic [15:0] fwd_hi, input logic [15:0] side,
                               input logic [15:0] gain, input logic [15:0] steer,
                               input logic [15:0] slow, input logic [15:0] stop);
      settle_block();
      csr_write(REG_OWN_RADIUS, rad);
      csr_write(REG_FWD_NEAR, fwd_lo);
      csr_write(REG_FWD_FAR, fwd_hi);
      csr_write(REG_SIDE_LIMIT, side);
      csr_write(REG_STEER_GAIN, gain);
      csr_write(REG_TURN_LIMIT, steer);
      csr_write(REG_SLOW_DIST, slow);
      csr_write(REG_STOP_DIST, stop);
   endtask

   // mostly points near or inside the accept window, some raw noise
   task automatic pick_point(output coord_type x, output coord_type y);
      int lo, hi, side;
      lo   = int'(shadow_cfg.fwd_near);
      hi   = int'(shadow_cfg.fwd_far);
      side = int'(shadow_cfg.side_limit);
      if ($urandom_range(0, 9) < 2 || lo > hi) begin
         x = CB'($urandom);
         y = CB'($urandom);
      end else begin
         case ($urandom_range(0, 7))
            0:       x = CB'(lo);
            1:       x = CB'(hi);
            2:       x = CB'(lo - 1);
            3:       x = CB'(hi + 1);
            default: x = CB'($urandom_range(lo, hi));
         endcase
         case ($urandom_range(0, 7))
            0:       y = CB'(side);
            1:       y = CB'(side + 1);
            2:       y = '0;
            default: y = CB'($urandom_range(0, side));
         endcase
         if ($urandom_range(0, 1) == 1) y = -y;
      end
   endtask

   task automatic send_random_frame();
      int        n;
      coord_type x, y;
      bit        pv;
      n = ($urandom_range(0, 19) == 0) ? 1 : $urandom_range(1, 10);
      for (int i = 0; i < n; i++) begin
         pick_point(x, y);
         pv = ($urandom_range(0, 9) != 0);
         if (i == n - 1 && $urandom_range(0, 3) == 0) pv = 1'b0;
         send_item(x, y, pv, i == n - 1);
         items_sent++;
      end
   endtask

   task automatic pick_random_config();
      int lo, hi;
      if ($urandom_range(0, 3) == 0) begin
         write_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
         lo = $urandom_range(0, 2000);
         hi = lo + $urandom_range(0, 20000);
         write_config(16'($urandom_range(0, 1500)), 16'(lo), 16'(hi),
                      16'($urandom_range(0, 20000)),
                      16'($urandom), 16'($urandom_range(0, 4095)),
                      16'($urandom_range(0, 8000)), 16'($urandom_range(0, 8000)));
      end
   endtask

   // reset values: empty frame, both sides, y on the axis, every filter, extremes
   task automatic test_directed_defaults();
      send_item(0, 0, 1'b0, 1'b1);
      send_item(1000, 800, 1'b1, 1'b0);
      send_item(2000, -1500, 1'b1, 1'b1);
      send_item(100, 100, 1'b1, 1'b0);
      send_item(400, 3000, 1'b1, 1'b0);
      send_item(6000, 0, 1'b1, 1'b0);
      send_item(1000, 6000, 1'b1, 1'b0);
      send_item(0, 0, 1'b0, 1'b1);
      send_item(700, 0, 1'b1, 1'b0);
      send_item(-1, -1, 1'b0, 1'b0);
      send_item(900, -65536, 1'b1, 1'b1);
      send_item(-65536, -65536, 1'b1, 1'b0);
      send_item(65535, 65535, 1'b1, 1'b0);
      send_item(500, 1, 1'b1, 1'b0);
      send_item(599, -1, 1'b1, 1'b1);
      send_item(3000, 400, 1'b1, 1'b0);
      send_item(3000, -400, 1'b1, 1'b1);
   endtask

   task automatic test_register_extremes();
      write_config(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
      send_item(0, 0, 1'b1, 1'b0);
      send_item(1, 0, 1'b1, 1'b0);
      send_item(0, 0, 1'b0, 1'b1);

      write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      csr_write(REG_UNUSED_LO, 16'h0000);
      csr_write(REG_UNUSED_HI, 16'h1234);
      send_item(65535, 65535, 1'b1, 1'b1);

      // upper steer bits are dropped by the register width
      write_config(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hF123, 16'd3000, 16'd2000);
      send_item(-65536, -65536, 1'b1, 1'b0);
      send_item(10, 5, 1'b1, 1'b0);
      send_item(10, -65535, 1'b1, 1'b1);
      send_item(20000, 30000, 1'b1, 1'b1);
   endtask

   task automatic test_random_frames();
      int target;
      for (int phase = 0; phase < 6; phase++) begin
         pick_random_config();
         idling_on = ($urandom_range(0, 3) != 0);
         target = items_sent + 130;
         for (int f = 0; items_sent < target; f++) begin
            send_random_frame();
            if (phase == 2 && f == 4) hold_until_answered();
         end
      end
   endtask

   task automatic test_steady_stream();
      write_config(RST_OWN_RADIUS, RST_FWD_NEAR, RST_FWD_FAR, RST_SIDE_LIMIT,
                   16'($urandom), 16'($urandom_range(0, 4095)), RST_SLOW_DIST,
                   RST_STOP_DIST);
      idling_on = 1'b0;
      while (items_sent < 1000) send_random_frame();
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         rsp_stall  = 1'b1;
         stall_left = $urandom_range(0, 3);
      end else begin
         rsp_stall = 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_cmds.size() == 0) begin
            report_mismatch("result transaction with nothing expected");
         end else begin
            want = expected_cmds.pop_front();
            if (rsp_speed_mm_s !== want.speed)
               report_mismatch($sformatf("speed got %0d expected %0d",
                                         rsp_speed_mm_s, want.speed));
            if (rsp_turn_rate_mrad !== want.turn)
               report_mismatch($sformatf("turn got %0d expected %0d",
                                         rsp_turn_rate_mrad, want.turn));
            if (rsp_left_clear_mm !== want.left)
               report_mismatch($sformatf("left clearance got %0d expected %0d",
                                         rsp_left_clear_mm, want.left));
            if (rsp_right_clear_mm !== want.right)
               report_mismatch($sformatf("right clearance got %0d expected %0d",
                                         rsp_right_clear_mm, want.right));
            if (rsp_empty_frame !== want.empty)
               report_mismatch($sformatf("empty flag got %0b expected %0b",
                                         rsp_empty_frame, want.empty));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      reset_shadow();
      repeat (10) @(negedge clock);
      reset = 1'b0;
      test_directed_defaults();
      test_register_extremes();
      test_random_frames();
      test_steady_stream();
      settle_block();
      if (err_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
